FILE: src/stpq_pkg.sv
// Shared types and constants for the sorted time priority queue.
package stpq_pkg;

	localparam int CAP_BITS = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_POP    = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_FIND   = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_MISS  = 2'd3
	} stat_t;

	// per-cell control from the queue controller
	typedef struct packed {
		logic ins;       // insert beat in progress
		logic del;       // pop or remove beat in progress
		logic vld;       // cell holds a live entry
		logic tail;      // cell is the first free slot
		logic after;     // cell index at or past the removed position
		logic right_vld; // right neighbor holds a live entry
	} cell_ctl_t;

endpackage

FILE: src/stpq_in_if.sv
// Request channel: one queue action per beat.
interface stpq_in_if #(
	parameter int KEY_BITS = 20,
	parameter int ID_BITS  = 16,
	parameter int POS_BITS = 4
);
	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic [KEY_BITS-1:0] expire_minutes;
	logic [ID_BITS-1:0]  food_id;
	logic [POS_BITS-1:0] position;

	modport source (output valid, action, expire_minutes, food_id, position, input ready);
	modport sink (input valid, action, expire_minutes, food_id, position, output ready);
endinterface

FILE: src/stpq_out_if.sv
// Response channel: one result per beat.
interface stpq_out_if #(
	parameter int KEY_BITS = 20,
	parameter int ID_BITS  = 16,
	parameter int POS_BITS = 4,
	parameter int CNT_BITS = 5
);
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [ID_BITS-1:0]  out_food_id;
	logic [KEY_BITS-1:0] out_minutes;
	logic [POS_BITS-1:0] found_position;
	logic [CNT_BITS-1:0] entry_count;

	modport source (output valid, status, out_food_id, out_minutes, found_position,
		entry_count, input ready);
	modport sink (input valid, status, out_food_id, out_minutes, found_position,
		entry_count, output ready);
endinterface

FILE: src/stpq_cfg_if.sv
// Configuration write channel for the capacity register.
interface stpq_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: src/stpq_cell.sv
// One queue slot: holds an entry and shifts with its neighbors.
module stpq_cell #(
	parameter int KEY_BITS = 20,
	parameter int ID_BITS  = 16
) (
	input  logic                clk,
	input  stpq_pkg::cell_ctl_t ctl,
	input  logic [KEY_BITS-1:0] new_key,
	input  logic [ID_BITS-1:0]  new_id,
	input  logic                left_gt,
	input  logic [KEY_BITS-1:0] left_key,
	input  logic [ID_BITS-1:0]  left_id,
	input  logic [KEY_BITS-1:0] right_key,
	input  logic [ID_BITS-1:0]  right_id,
	output logic [KEY_BITS-1:0] key_q,
	output logic [ID_BITS-1:0]  id_q,
	output logic                gt,
	output logic                match
);
	import stpq_pkg::*;

	// new key goes before this entry (strictly less keeps equal keys stable)
	assign gt    = ctl.vld && (new_key < key_q);
	assign match = ctl.vld && (new_id == id_q);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (left_gt) begin
				key_q <= left_key;
				id_q  <= left_id;
			end else if (gt || ctl.tail) begin
				key_q <= new_key;
				id_q  <= new_id;
			end
		end else if (ctl.del && ctl.after && ctl.right_vld) begin
			key_q <= right_key;
			id_q  <= right_id;
		end
	end

endmodule

FILE: src/sorted_time_priority_queue_core.sv
// Top level: sorted priority queue built as a row of shifting cells.
// Holds up to DEPTH entries sorted by ascending time key; equal keys keep arrival order. Every
// action (insert, pop head, remove at position, find by id) is done by the whole row at once: all
// cells compare against the request in parallel and shift one place toward or away from the
// head at the same edge, so one request beat is taken per cycle while the response register is
// free or being drained. The response is registered and appears in the cycle after its request is
// taken. The capacity register limits the entries in use to min(capacity, DEPTH); write it only while idle.
module sorted_time_priority_queue_core #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 20,
	parameter int ID_BITS  = 16
) (
	input logic         clk,
	input logic         arst_n,
	stpq_in_if.sink     req,
	stpq_out_if.source  rsp,
	stpq_cfg_if.sink    cfg
);
	import stpq_pkg::*;

	localparam int POS_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int CMP_W    = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

	logic [CAP_BITS-1:0] cap_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0] cnt_nxt;
	logic                acc;
	logic                full;
	logic                do_ins;
	logic                do_del;
	logic [POS_BITS-1:0] eff_pos;
	act_t                act;
	stat_t               st;

	logic [KEY_BITS-1:0] key_arr [DEPTH];
	logic [ID_BITS-1:0]  id_arr  [DEPTH];
	cell_ctl_t           ctl     [DEPTH];
	logic [DEPTH-1:0]    gt_vec;
	logic [DEPTH-1:0]    match_vec;
	logic [DEPTH-1:0]    low_vec;
	logic [DEPTH-1:0]    sel_vec;
	logic [DEPTH-1:0]    vld_vec;

	logic [KEY_BITS-1:0] sel_key;
	logic [ID_BITS-1:0]  sel_id;
	logic [POS_BITS-1:0] hit_pos;
	logic [KEY_BITS-1:0] o_key;
	logic [ID_BITS-1:0]  o_id;
	logic [POS_BITS-1:0] o_fpos;

	logic                rsp_vld_q;
	stat_t               st_q;
	logic [ID_BITS-1:0]  o_id_q;
	logic [KEY_BITS-1:0] o_key_q;
	logic [POS_BITS-1:0] o_fpos_q;

	assign cfg.ready = 1'b1;
	assign req.ready = !rsp_vld_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign act       = act_t'(req.action);
	assign eff_pos   = (act == ACT_POP) ? '0 : req.position;
	assign full      = (cnt_q >= CNT_BITS'(DEPTH)) || (CMP_W'(cnt_q) >= CMP_W'(cap_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cap_q <= cfg.data;
		end
	end

	// per-cell control and onehot selects
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			vld_vec[i]       = CNT_BITS'(i) < cnt_q;
			sel_vec[i]       = vld_vec[i] && (POS_BITS'(i) == eff_pos);
			ctl[i].ins       = acc && do_ins;
			ctl[i].del       = acc && do_del;
			ctl[i].vld       = vld_vec[i];
			ctl[i].tail      = CNT_BITS'(i) == cnt_q;
			ctl[i].after     = POS_BITS'(i) >= eff_pos;
			ctl[i].right_vld = (i + 1 < DEPTH) ? (CNT_BITS'(i + 1) < cnt_q) : 1'b0;
		end
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic                l_gt;
			logic [KEY_BITS-1:0] l_key;
			logic [ID_BITS-1:0]  l_id;
			logic [KEY_BITS-1:0] r_key;
			logic [ID_BITS-1:0]  r_id;

			if (g == 0) begin : g_head
				assign l_gt  = 1'b0;
				assign l_key = '0;
				assign l_id  = '0;
			end else begin : g_mid
				assign l_gt  = gt_vec[g-1];
				assign l_key = key_arr[g-1];
				assign l_id  = id_arr[g-1];
			end

			if (g == DEPTH - 1) begin : g_last
				assign r_key = '0;
				assign r_id  = '0;
			end else begin : g_inner
				assign r_key = key_arr[g+1];
				assign r_id  = id_arr[g+1];
			end

			stpq_cell #(
				.KEY_BITS (KEY_BITS),
				.ID_BITS  (ID_BITS)
			) u_cell (
				.clk       (clk),
				.ctl       (ctl[g]),
				.new_key   (req.expire_minutes),
				.new_id    (req.food_id),
				.left_gt   (l_gt),
				.left_key  (l_key),
				.left_id   (l_id),
				.right_key (r_key),
				.right_id  (r_id),
				.key_q     (key_arr[g]),
				.id_q      (id_arr[g]),
				.gt        (gt_vec[g]),
				.match     (match_vec[g])
			);
		end
	endgenerate

	// lowest matching cell: isolate the lowest set bit, then encode
	assign low_vec = match_vec & (~match_vec + DEPTH'(1));

	always_comb begin
		sel_key = '0;
		sel_id  = '0;
		hit_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_key = sel_key | (sel_vec[i] ? key_arr[i] : '0);
			sel_id  = sel_id | (sel_vec[i] ? id_arr[i] : '0);
			hit_pos = hit_pos | (low_vec[i] ? POS_BITS'(i) : '0);
		end
	end

	always_comb begin
		st      = ST_OK;
		do_ins  = 1'b0;
		do_del  = 1'b0;
		o_key   = '0;
		o_id    = '0;
		o_fpos  = '0;
		cnt_nxt = cnt_q;
		unique case (act)
			ACT_INSERT: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					do_ins  = 1'b1;
					cnt_nxt = cnt_q + CNT_BITS'(1);
				end
			end
			ACT_POP: begin
				if (cnt_q == '0) begin
					st = ST_EMPTY;
				end else begin
					do_del  = 1'b1;
					o_key   = sel_key;
					o_id    = sel_id;
					cnt_nxt = cnt_q - CNT_BITS'(1);
				end
			end
			ACT_REMOVE: begin
				if (CNT_BITS'(req.position) >= cnt_q) begin
					st = ST_MISS;
				end else begin
					do_del  = 1'b1;
					o_key   = sel_key;
					o_id    = sel_id;
					cnt_nxt = cnt_q - CNT_BITS'(1);
				end
			end
			ACT_FIND: begin
				if (|match_vec) begin
					o_fpos = hit_pos;
				end else begin
					st = ST_MISS;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q     <= cnt_nxt;
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			st_q     <= st;
			o_id_q   <= o_id;
			o_key_q  <= o_key;
			o_fpos_q <= o_fpos;
		end
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.status         = st_q;
	assign rsp.out_food_id    = o_id_q;
	assign rsp.out_minutes    = o_key_q;
	assign rsp.found_position = o_fpos_q;
	assign rsp.entry_count    = cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(DEPTH))
		else $error("entry count above depth");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && do_ins |=> cnt_q == $past(cnt_q) + CNT_BITS'(1))
		else $error("insert did not grow the count");

	a_find_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc && act == ACT_FIND |=> cnt_q == $past(cnt_q))
		else $error("find changed the count");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> (({gt_vec[DEPTH-2:0], 1'b0} & vld_vec & ~gt_vec) == '0))
		else $error("cell row not sorted");

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel_vec))
		else $error("more than one cell selected");

endmodule

FILE: tb/stpq_checker.sv
// Scoreboard for the sorted time priority queue: predicts each response and checks it.
`timescale 1ns / 100ps

module stpq_checker #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 20,
	parameter int ID_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_ready,
	input  logic [1:0]                   req_action,
	input  logic [KEY_BITS-1:0]          req_minutes,
	input  logic [ID_BITS-1:0]           req_food_id,
	input  logic [$clog2(DEPTH)-1:0]     req_position,
	input  logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  logic [1:0]                   rsp_status,
	input  logic [ID_BITS-1:0]           rsp_food_id,
	input  logic [KEY_BITS-1:0]          rsp_minutes,
	input  logic [$clog2(DEPTH)-1:0]     rsp_found_position,
	input  logic [stpq_pkg::CAP_BITS-1:0] rsp_entry_count,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [stpq_pkg::CAP_BITS-1:0] cfg_data,
	output int                           fail_count,
	output int                           pending,
	output int                           n_checked,
	output int                           n_ok,
	output int                           n_full,
	output int                           n_empty,
	output int                           n_miss
);
	import stpq_pkg::*;

	localparam int POS_BITS = $clog2(DEPTH);

	typedef struct packed {
		stat_t                status;
		logic [ID_BITS-1:0]   food_id;
		logic [KEY_BITS-1:0]  minutes;
		logic [POS_BITS-1:0]  found_at;
		logic [CAP_BITS-1:0]  count;
	} queue_result_t;

	logic [KEY_BITS-1:0] model_key [DEPTH];
	logic [ID_BITS-1:0]  model_id [DEPTH];
	int                  held;
	logic [CAP_BITS-1:0] capacity_reg;
	queue_result_t       pending_results [$];
	queue_result_t       want;
	queue_result_t       got;

	task automatic take_entry(input int at, inout queue_result_t r);
		r.food_id = model_id[at];
		r.minutes = model_key[at];
		for (int i = at; i + 1 < held; i++) begin
			model_key[i] = model_key[i+1];
			model_id[i]  = model_id[i+1];
		end
		held--;
	endtask

	task automatic step_queue(input act_t act, input logic [KEY_BITS-1:0] key,
			input logic [ID_BITS-1:0] id, input logic [POS_BITS-1:0] pos,
			output queue_result_t r);
		int slot;
		int lim;
		r = '0;
		r.status = ST_OK;
		lim = (capacity_reg < DEPTH) ? int'(capacity_reg) : DEPTH;
		case (act)
			ACT_INSERT: begin
				if (held >= lim) begin
					r.status = ST_FULL;
				end else begin
					slot = held;
					for (int i = 0; i < held; i++) begin
						if (key < model_key[i]) begin
							slot = i;
							break;
						end
					end
					for (int i = held; i > slot; i--) begin
						model_key[i] = model_key[i-1];
						model_id[i]  = model_id[i-1];
					end
					model_key[slot] = key;
					model_id[slot]  = id;
					held++;
				end
			end
			ACT_POP: begin
				if (held == 0)
					r.status = ST_EMPTY;
				else
					take_entry(0, r);
			end
			ACT_REMOVE: begin
				if (int'(pos) >= held)
					r.status = ST_MISS;
				else
					take_entry(int'(pos), r);
			end
			default: begin
				r.status = ST_MISS;
				for (int i = 0; i < held; i++) begin
					if (model_id[i] == id) begin
						r.status   = ST_OK;
						r.found_at = POS_BITS'(i);
						break;
					end
				end
			end
		endcase
		r.count = CAP_BITS'(held);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			capacity_reg = CAP_RESET;
			pending_results.delete();
			pending    <= 0;
			fail_count <= 0;
			n_checked  <= 0;
			n_ok       <= 0;
			n_full     <= 0;
			n_empty    <= 0;
			n_miss     <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				got.status   = stat_t'(rsp_status);
				got.food_id  = rsp_food_id;
				got.minutes  = rsp_minutes;
				got.found_at = rsp_found_position;
				got.count    = rsp_entry_count;
				if (pending_results.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 100)
						$display("%0t: response beat with nothing outstanding, actual status %0d",
							$time, rsp_status);
				end else begin
					want = pending_results.pop_front();
					n_checked <= n_checked + 1;
					if (got.status !== want.status || got.food_id !== want.food_id ||
							got.minutes !== want.minutes || got.found_at !== want.found_at ||
							got.count !== want.count) begin
						fail_count <= fail_count + 1;
						if (fail_count < 100)
							$display({"%0t: mismatch, expected st %0d id %h min %h pos %0d cnt %0d,",
								" actual st %0d id %h min %h pos %0d cnt %0d"}, $time,
								want.status, want.food_id, want.minutes, want.found_at, want.count,
								rsp_status, rsp_food_id, rsp_minutes, rsp_found_position,
								rsp_entry_count);
					end
					case (want.status)
						ST_OK:    n_ok    <= n_ok + 1;
						ST_FULL:  n_full  <= n_full + 1;
						ST_EMPTY: n_empty <= n_empty + 1;
						default:  n_miss  <= n_miss + 1;
					endcase
				end
			end
			if (cfg_valid && cfg_ready)
				capacity_reg = cfg_data;
			if (req_valid && req_ready) begin
				step_queue(act_t'(req_action), req_minutes, req_food_id, req_position, want);
				pending_results.push_back(want);
			end
			pending <= pending_results.size();
		end
	end

endmodule

FILE: tb/tb.sv
// Testbench top: drives requests, capacity writes and response back-pressure, reports the verdict.
`timescale 1ns / 100ps

module tb;
	import stpq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int KEY_BITS     = 20;
	localparam int ID_BITS      = 16;
	localparam int LIMIT_CYCLES = 500000;
	localparam int N_PHASES     = 10;
	localparam int N_SEGMENTS   = 6;
	localparam int SEGMENT_LEN  = 32;

	logic clk = 1'b0;
	logic arst_n;

	stpq_in_if  req ();
	stpq_out_if rsp ();
	stpq_cfg_if cfg ();

	int fail_count, pending, n_checked, n_ok, n_full, n_empty, n_miss;
	int cycle_count = 0;
	int items_sent = 0;
	int cap_writes = 0;
	int phase_caps [N_PHASES] = '{16, 1, 31, 0, 4, 17, 2, 9, 16, 15};
	int ins_pct;
	int stall;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	act_t                rnd_act;
	logic [KEY_BITS-1:0] rnd_key;
	logic [ID_BITS-1:0]  rnd_id;
	logic [3:0]          rnd_pos;

	sorted_time_priority_queue_core #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS),
		.ID_BITS(ID_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	stpq_checker #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS),
		.ID_BITS(ID_BITS)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_action(req.action),
		.req_minutes(req.expire_minutes),
		.req_food_id(req.food_id),
		.req_position(req.position),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.rsp_status(rsp.status),
		.rsp_food_id(rsp.out_food_id),
		.rsp_minutes(rsp.out_minutes),
		.rsp_found_position(rsp.found_position),
		.rsp_entry_count(rsp.entry_count),
		.cfg_valid(cfg.valid),
		.cfg_ready(cfg.ready),
		.cfg_data(cfg.data),
		.fail_count(fail_count),
		.pending(pending),
		.n_checked(n_checked),
		.n_ok(n_ok),
		.n_full(n_full),
		.n_empty(n_empty),
		.n_miss(n_miss)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// response back-pressure: random stall before each beat
	initial begin
		rsp.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (rsp.valid !== 1'b1);
		end
	end

	task automatic send_item(input act_t act, input logic [KEY_BITS-1:0] key,
			input logic [ID_BITS-1:0] id, input logic [3:0] pos);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.action         <= act;
		req.expire_minutes <= key;
		req.food_id        <= id;
		req.position       <= pos;
		req.valid          <= 1'b1;
		do @(posedge clk); while (req.ready !== 1'b1);
		items_sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_BITS-1:0] value);
		drain();
		cfg.data  <= value;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		cap_writes++;
	endtask

	initial begin
		arst_n             <= 1'b0;
		req.valid          <= 1'b0;
		req.action         <= ACT_INSERT;
		req.expire_minutes <= '0;
		req.food_id        <= '0;
		req.position       <= '0;
		cfg.valid          <= 1'b0;
		cfg.data           <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, extremes, ties, lookups, capacity limits
		send_item(ACT_POP, '0, '0, '0);
		send_item(ACT_REMOVE, '0, '0, 4'd0);
		send_item(ACT_FIND, '0, 16'd0, '0);
		send_item(ACT_INSERT, 20'hFFFFF, 16'hFFFF, 4'hF);
		send_item(ACT_INSERT, 20'h00000, 16'h0000, '0);
		send_item(ACT_INSERT, 20'd5, 16'd1, '0);
		send_item(ACT_INSERT, 20'd5, 16'd2, '0);
		send_item(ACT_INSERT, 20'd5, 16'd1, '0);
		send_item(ACT_FIND, 20'hFFFFF, 16'd1, '0);
		send_item(ACT_FIND, '0, 16'hFFFF, '0);
		send_item(ACT_FIND, '0, 16'h1234, '0);
		send_item(ACT_REMOVE, '0, '0, 4'd15);
		send_item(ACT_REMOVE, '0, '0, 4'd2);
		send_item(ACT_REMOVE, '0, '0, 4'd3);
		send_item(ACT_POP, '0, '0, '0);
		write_capacity(5'd2);
		send_item(ACT_INSERT, 20'd3, 16'd7, '0);
		write_capacity(5'd1);
		send_item(ACT_INSERT, 20'd3, 16'd8, '0);
		send_item(ACT_POP, '0, '0, '0);
		write_capacity(5'd0);
		send_item(ACT_INSERT, 20'd1, 16'd9, '0);
		send_item(ACT_FIND, '0, 16'd1, '0);

		for (int p = 0; p < N_PHASES; p++) begin
			write_capacity(phase_caps[p][CAP_BITS-1:0]);
			for (int s = 0; s < N_SEGMENTS; s++) begin
				case ($urandom_range(0, 3))
					0:       ins_pct = 15;
					1:       ins_pct = 50;
					2:       ins_pct = 80;
					default: ins_pct = 95;
				endcase
				tx_burst = ($urandom_range(0, 3) == 0);
				rx_burst = ($urandom_range(0, 3) == 0);
				for (int k = 0; k < SEGMENT_LEN; k++) begin
					if ($urandom_range(0, 99) < ins_pct) begin
						rnd_act = ACT_INSERT;
					end else begin
						case ($urandom_range(0, 9))
							0, 1, 2, 3: rnd_act = ACT_POP;
							4, 5, 6:    rnd_act = ACT_REMOVE;
							default:    rnd_act = ACT_FIND;
						endcase
					end
					case ($urandom_range(0, 3))
						0:       rnd_key = KEY_BITS'($urandom_range(0, 7));
						1:       rnd_key = KEY_BITS'($urandom);
						2:       rnd_key = $urandom_range(0, 1) ? '1 : '0;
						default: rnd_key = KEY_BITS'($urandom_range(0, 1000));
					endcase
					rnd_id = ($urandom_range(0, 3) == 0) ? ID_BITS'($urandom)
						: ID_BITS'($urandom_range(0, 15));
					rnd_pos = $urandom_range(0, 1) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(0, 3));
					send_item(rnd_act, rnd_key, rnd_id, rnd_pos);
				end
			end
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		drain();
		repeat (5) @(posedge clk);

		$display("run covered %0d requests over %0d capacity writes, %0d responses checked",
			items_sent, cap_writes, n_checked);
		$display("response mix: %0d ok, %0d full, %0d empty, %0d miss",
			n_ok, n_full, n_empty, n_miss);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
